@@ design/ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// ovl_pkg
// Types, constants and the arctangent table shared by the omni velocity loop.
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam int CW_W  = 36;   // cordic x/y datapath width
    localparam int ANG_W = 32;   // cordic angle width, one turn = 2^32
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int DIV_STEPS = 19;

    localparam logic [29:0] KQ30       = 30'd652032875;
    localparam logic [14:0] KP_X_Q15   = 15'd22938;
    localparam logic [16:0] GAIN_Q16   = 17'd76895;
    localparam logic [18:0] ROT_Q16    = 19'd333217;
    localparam logic [15:0] DEG120     = 16'd21845;
    localparam int          AXIS_MAX   = 1500;
    localparam int          AXIS_DEAD  = 50;
    localparam int          ERR_CAP    = 250;
    localparam int          ERR_MIN    = 50;
    localparam int          SPIN_TRIP  = 300;
    localparam int          SPIN_CLAMP = 200;
    localparam int          SPEED_MARGIN = 1000;
    localparam logic [3:0]  EVT_MAX    = 4'd10;
    localparam logic [3:0]  EVT_SAT    = 4'd11;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_SCALE  = 3'd4;

    typedef struct packed {
        logic        [12:0] actual_speed;
        logic signed [15:0] actual_direction;
        logic signed [15:0] heading;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] wheel_one_rate;
        logic signed [31:0] wheel_two_rate;
        logic signed [31:0] wheel_three_rate;
        logic               speed_over_flag;
        logic               spin_high_flag;
        logic               spin_low_flag;
    } out_item_t;

    typedef struct packed {
        logic                   start;
        logic                   vec_mode;
        logic signed [CW_W-1:0] x;
        logic signed [CW_W-1:0] y;
        logic [ANG_W-1:0]       z;
    } cordic_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [CW_W-1:0] x;
        logic signed [CW_W-1:0] y;
        logic [ANG_W-1:0]       z;
    } cordic_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T_GO, ST_T_RUN, ST_T_MC, ST_T_MS,
        ST_A_GO, ST_A_RUN, ST_A_MC, ST_A_MS, ST_E_X, ST_E_Y,
        ST_V1_GO, ST_V1_RUN, ST_V1_MAG, ST_DIV,
        ST_V2_GO, ST_V2_RUN, ST_SPD, ST_GS, ST_SP, ST_SPIN, ST_ROTM, ST_ROTR,
        ST_W_GO, ST_W_RUN, ST_W_MC, ST_W_V, ST_W_PS, ST_W_OUT, ST_DONE
    } state_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  return 32'h20000000;
            5'd1:  return 32'h12E4051E;
            5'd2:  return 32'h09FB385B;
            5'd3:  return 32'h051111D4;
            5'd4:  return 32'h028B0D43;
            5'd5:  return 32'h0145D7E1;
            5'd6:  return 32'h00A2F61E;
            5'd7:  return 32'h00517C55;
            5'd8:  return 32'h0028BE53;
            5'd9:  return 32'h00145F2E;
            5'd10: return 32'h000A2F98;
            5'd11: return 32'h000517CC;
            5'd12: return 32'h00028BE6;
            5'd13: return 32'h000145F3;
            5'd14: return 32'h0000A2F9;
            5'd15: return 32'h0000517C;
            5'd16: return 32'h000028BE;
            5'd17: return 32'h0000145F;
            5'd18: return 32'h00000A2F;
            5'd19: return 32'h00000517;
            5'd20: return 32'h0000028B;
            5'd21: return 32'h00000145;
            5'd22: return 32'h000000A2;
            5'd23: return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

@@ design/ovl_cordic.sv @@
// ----------------------------------------------------------------------------
// ovl_cordic
// Shared iterative cordic, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module ovl_cordic #(
    parameter int STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ovl_pkg::cordic_req_t req,
    output ovl_pkg::cordic_rsp_t rsp
);
    import ovl_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic                   run_reg, done_reg;
    logic                   vec_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [CW_W-1:0] x_reg, y_reg;
    logic [ANG_W-1:0]       z_reg;

    logic signed [CW_W-1:0] dx, dy;
    logic [ANG_W-1:0]       a;
    logic                   neg_dir;

    always_comb begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        a  = atan_entry(5'(cnt_reg));
        // rotation drives z to zero, vectoring drives y to zero
        neg_dir = vec_reg ? y_reg[CW_W-1] : ~z_reg[ANG_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                if (cnt_reg == LAST) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            z_reg   <= req.z;
            vec_reg <= req.vec_mode;
        end else if (run_reg) begin
            if (neg_dir) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - a;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + a;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg))
        else $error("cordic done without a run");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg)
        else $error("cordic still running at done");
    a_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg && !req.start && cnt_reg == LAST) |=> done_reg)
        else $error("cordic missed its done");

endmodule

@@ design/omni_velocity_loop_three_wheel.sv @@
// ----------------------------------------------------------------------------
// omni_velocity_loop_three_wheel
// Velocity loop and inverse kinematics of a three-wheel omni base.
// ----------------------------------------------------------------------------
//  channel  ports                         payload
//  input    s_valid s_ready s_data        in_item_t
//  result   m_valid m_ready m_data        out_item_t
//  config   cfg_valid cfg_ready           cfg_index, cfg_data
//
//  an item runs from input transfer to m_valid through seven passes of the one
//  shared cordic with multiplier steps in between, and through both 19-step
//  divisions when the error magnitude reaches the cap
//  s_ready is high only while the sequencer is idle;
//  cfg_ready is always high
//  synchronous active-low reset sets state, output valid and configuration, clears counters and flags
//  a result waits in the output register; the next item is taken meanwhile and
//  the sequencer holds in its last state while that result is still waiting
// ----------------------------------------------------------------------------
module omni_velocity_loop_three_wheel #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ovl_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ovl_pkg::out_item_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ovl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ovl_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import ovl_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic        [12:0] tspeed_reg, lim_reg;
    logic signed [15:0] tdir_reg;
    logic signed [10:0] tspin_reg;
    logic        [23:0] ps_reg;

    logic [3:0] cnt_speed_reg, cnt_hi_reg, cnt_lo_reg;
    logic [2:0] sticky_reg;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    // datapath
    in_item_t           in_reg;
    logic               flip_reg, zero_reg, dsel_reg, dneg_reg;
    logic signed [15:0] trig_c_reg, trig_s_reg;
    logic signed [15:0] tx_reg, ty_reg, ax_reg, ay_reg;
    logic signed [11:0] ex_reg, ey_reg;
    logic        [15:0] m_reg, dir_reg;
    logic        [18:0] num_reg;
    logic        [15:0] rem_reg;
    logic        [4:0]  dcnt_reg;
    logic        [14:0] spd_reg;
    logic signed [15:0] spin_reg, rot_reg, v_reg;
    logic        [1:0]  wk_reg;
    logic signed [31:0] w1_reg, w2_reg, w3_reg;
    logic signed [65:0] prod_reg;

    cordic_req_t req;
    cordic_rsp_t rsp;

    ovl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    function automatic logic signed [65:0] rsh(input logic signed [65:0] p, input int n);
        return (p + (66'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [11:0] axis_clamp(input logic signed [15:0] e);
        logic signed [15:0] a;
        a = e[15] ? -e : e;
        if (a >= 16'(AXIS_MAX)) return e[15] ? -12'sd1500 : 12'sd1500;
        if (a <= 16'(AXIS_DEAD)) return 12'sd0;
        return 12'(e);
    endfunction

    // {flag, count} after one clamp event
    function automatic logic [4:0] bump(input logic [3:0] c);
        logic [3:0] n;
        n = c + 1'b1;
        if (n > EVT_MAX) return {1'b1, EVT_SAT};
        return {1'b0, n};
    endfunction

    // post-processing of the cordic rotation result, q1.15 with saturation
    function automatic logic signed [15:0] trig_out(input logic signed [CW_W-1:0] v,
                                                    input logic flip);
        logic signed [CW_W-1:0] r;
        logic signed [15:0]     s;
        r = (v + (CW_W'(1) <<< 14)) >>> 15;
        if (r > CW_W'(32767))       s = 16'sd32767;
        else if (r < -CW_W'(32767)) s = -16'sd32767;
        else                        s = 16'(r);
        return flip ? -s : s;
    endfunction

    // rounded product views
    logic signed [65:0] r15, r16, r46;
    assign r15 = rsh(prod_reg, 15);
    assign r16 = rsh(prod_reg, 16);
    assign r46 = rsh(prod_reg, 46);

    // rotation request angle
    logic [15:0] rot_ang;
    logic        rot_flip;
    logic [15:0] rel;
    always_comb begin
        rel = dir_reg - 16'(in_reg.heading);
        case (state_reg)
            ST_T_GO: rot_ang = 16'(tdir_reg);
            ST_A_GO: rot_ang = 16'(in_reg.actual_direction);
            default: begin
                case (wk_reg)
                    2'd0:    rot_ang = rel;
                    2'd1:    rot_ang = rel + DEG120;
                    default: rot_ang = DEG120 - rel;
                endcase
            end
        endcase
        rot_flip = rot_ang[15] ^ rot_ang[14];
    end

    // vectoring request operands
    logic signed [16:0] vx, vy, vxn, vyn;
    always_comb begin
        if (state_reg == ST_V1_GO) begin
            vx = 17'(ex_reg);
            vy = 17'(ey_reg);
        end else begin
            vx = 17'(ex_reg) + 17'(tx_reg);
            vy = 17'(ey_reg) + 17'(ty_reg);
        end
        vxn = vx[16] ? -vx : vx;
        vyn = vx[16] ? -vy : vy;
    end

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T_MC: begin mul_a = signed'(33'(tspeed_reg)); mul_b = 33'(trig_c_reg); end
            ST_T_MS: begin mul_a = signed'(33'(tspeed_reg)); mul_b = 33'(trig_s_reg); end
            ST_A_MC: begin
                mul_a = signed'(33'(in_reg.actual_speed));
                mul_b = 33'(trig_c_reg);
            end
            ST_A_MS: begin
                mul_a = signed'(33'(in_reg.actual_speed));
                mul_b = 33'(trig_s_reg);
            end
            ST_E_X: begin
                mul_a = 33'(axis_clamp(tx_reg - ax_reg));
                mul_b = signed'(33'(KP_X_Q15));
            end
            ST_V1_RUN, ST_V2_RUN: begin
                mul_a = rsp.x[32:0];
                mul_b = signed'(33'(KQ30));
            end
            ST_GS:   begin mul_a = signed'(33'(spd_reg)); mul_b = signed'(33'(GAIN_Q16)); end
            ST_SP:   begin mul_a = 33'(tspin_reg); mul_b = signed'(33'(GAIN_Q16)); end
            ST_ROTM: begin mul_a = 33'(spin_reg); mul_b = signed'(33'(ROT_Q16)); end
            ST_W_MC: begin mul_a = signed'(33'(spd_reg)); mul_b = 33'(trig_c_reg); end
            ST_W_PS: begin mul_a = 33'(v_reg); mul_b = signed'(33'(ps_reg)); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_T_GO;
            ST_T_GO:   state_next = ST_T_RUN;
            ST_T_RUN:  if (rsp.done) state_next = ST_T_MC;
            ST_T_MC:   state_next = ST_T_MS;
            ST_T_MS:   state_next = ST_A_GO;
            ST_A_GO:   state_next = ST_A_RUN;
            ST_A_RUN:  if (rsp.done) state_next = ST_A_MC;
            ST_A_MC:   state_next = ST_A_MS;
            ST_A_MS:   state_next = ST_E_X;
            ST_E_X:    state_next = ST_E_Y;
            ST_E_Y:    state_next = ST_V1_GO;
            ST_V1_GO:  state_next = ST_V1_RUN;
            ST_V1_RUN: if (rsp.done) state_next = ST_V1_MAG;
            ST_V1_MAG: state_next = (r46[15:0] >= 16'(ERR_CAP)) ? ST_DIV : ST_V2_GO;
            ST_DIV:    if (dsel_reg && dcnt_reg == 5'(DIV_STEPS - 1)) state_next = ST_V2_GO;
            ST_V2_GO:  state_next = ST_V2_RUN;
            ST_V2_RUN: if (rsp.done) state_next = ST_SPD;
            ST_SPD:    state_next = ST_GS;
            ST_GS:     state_next = ST_SP;
            ST_SP:     state_next = ST_SPIN;
            ST_SPIN:   state_next = ST_ROTM;
            ST_ROTM:   state_next = ST_ROTR;
            ST_ROTR:   state_next = ST_W_GO;
            ST_W_GO:   state_next = ST_W_RUN;
            ST_W_RUN:  if (rsp.done) state_next = ST_W_MC;
            ST_W_MC:   state_next = ST_W_V;
            ST_W_V:    state_next = ST_W_PS;
            ST_W_PS:   state_next = ST_W_OUT;
            ST_W_OUT:  state_next = (wk_reg == 2'd2) ? ST_DONE : ST_W_GO;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        req.start    = 1'b0;
        req.vec_mode = 1'b0;
        req.x        = signed'(CW_W'(KQ30));
        req.y        = '0;
        req.z        = {rot_ang ^ {rot_flip, 15'd0}, 16'd0};
        case (state_reg)
            ST_T_GO, ST_A_GO, ST_W_GO: req.start = 1'b1;
            ST_V1_GO, ST_V2_GO: begin
                req.start    = 1'b1;
                req.vec_mode = 1'b1;
                req.x        = CW_W'(vxn) <<< 16;
                req.y        = CW_W'(vyn) <<< 16;
                req.z        = vx[16] ? 32'h80000000 : 32'h0;
            end
            default: req.start = 1'b0;
        endcase
    end

    // divider step
    logic [16:0] trial;
    logic        qbit;
    logic [11:0] abs_ey;
    always_comb begin
        trial  = {rem_reg, num_reg[18]};
        qbit   = (trial >= {1'b0, m_reg});
        abs_ey = ey_reg[11] ? 12'(-ey_reg) : 12'(ey_reg);
    end

    logic [15:0] spd_lim;
    assign spd_lim = 16'(lim_reg) + 16'(SPEED_MARGIN);

    logic [4:0] b_speed, b_hi, b_lo;
    assign b_speed = bump(cnt_speed_reg);
    assign b_hi    = bump(cnt_hi_reg);
    assign b_lo    = bump(cnt_lo_reg);

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            tspeed_reg    <= '0;
            tdir_reg      <= '0;
            tspin_reg     <= '0;
            lim_reg       <= 13'd2000;
            ps_reg        <= 24'd65536;
            cnt_speed_reg <= '0;
            cnt_hi_reg    <= '0;
            cnt_lo_reg    <= '0;
            sticky_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)                        m_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TARGET_SPEED: tspeed_reg <= cfg_data[12:0];
                    REG_TARGET_DIR:   tdir_reg   <= signed'(cfg_data[15:0]);
                    REG_TARGET_SPIN:  tspin_reg  <= signed'(cfg_data[10:0]);
                    REG_SPEED_LIMIT:  lim_reg    <= cfg_data[12:0];
                    REG_PULSE_SCALE:  ps_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_SP && r16[15:0] > spd_lim) begin
                cnt_speed_reg <= b_speed[3:0];
                if (b_speed[4]) sticky_reg[0] <= 1'b1;
            end
            if (state_reg == ST_SPIN) begin
                if (signed'(r16[15:0]) > 16'sd300) begin
                    cnt_hi_reg <= b_hi[3:0];
                    if (b_hi[4]) sticky_reg[1] <= 1'b1;
                end else if (signed'(r16[15:0]) < -16'sd300) begin
                    cnt_lo_reg <= b_lo[3:0];
                    if (b_lo[4]) sticky_reg[2] <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE:  if (s_valid) in_reg <= s_data;
            ST_T_GO, ST_W_GO: flip_reg <= rot_flip;
            ST_A_GO: begin
                flip_reg <= rot_flip;
                ty_reg   <= r15[15:0];
            end
            ST_T_RUN, ST_A_RUN, ST_W_RUN: begin
                if (rsp.done) begin
                    trig_c_reg <= trig_out(rsp.x, flip_reg);
                    trig_s_reg <= trig_out(rsp.y, flip_reg);
                end
            end
            ST_T_MS:  tx_reg <= r15[15:0];
            ST_A_MS:  ax_reg <= r15[15:0];
            ST_E_X:   ay_reg <= r15[15:0];
            ST_E_Y: begin
                ex_reg <= r15[11:0];
                ey_reg <= axis_clamp(ty_reg - ay_reg);
            end
            ST_V1_MAG: begin
                m_reg    <= r46[15:0];
                dsel_reg <= 1'b0;
                dcnt_reg <= '0;
                rem_reg  <= '0;
                dneg_reg <= ex_reg[11];
                num_reg  <= 19'(ex_reg[11] ? 12'(-ex_reg) : 12'(ex_reg)) * 19'(ERR_CAP);
                if (r46[15:0] < 16'(ERR_MIN)) begin
                    ex_reg <= '0;
                    ey_reg <= '0;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == 5'(DIV_STEPS - 1)) begin
                    // last quotient bit lands here
                    if (!dsel_reg) begin
                        ex_reg <= dneg_reg ? -12'({num_reg[17:0], qbit})
                                           : 12'({num_reg[17:0], qbit});
                        dsel_reg <= 1'b1;
                        dcnt_reg <= '0;
                        rem_reg  <= '0;
                        dneg_reg <= ey_reg[11];
                        num_reg  <= 19'(abs_ey) * 19'(ERR_CAP);
                    end else begin
                        ey_reg <= dneg_reg ? -12'({num_reg[17:0], qbit})
                                           : 12'({num_reg[17:0], qbit});
                    end
                end else begin
                    num_reg  <= {num_reg[17:0], qbit};
                    rem_reg  <= qbit ? 16'(trial - {1'b0, m_reg}) : trial[15:0];
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
            ST_V2_GO: zero_reg <= (vx == 17'sd0) && (vy == 17'sd0);
            ST_V2_RUN: begin
                if (rsp.done) dir_reg <= zero_reg ? 16'd0 : 16'((rsp.z + 32'h8000) >> 16);
            end
            ST_SPD: spd_reg <= (r46[15:0] >= 16'(lim_reg)) ? 15'(lim_reg) : r46[14:0];
            ST_SP:  if (r16[15:0] > spd_lim) spd_reg <= 15'(lim_reg); else spd_reg <= r16[14:0];
            ST_SPIN: begin
                if (signed'(r16[15:0]) > 16'(SPIN_TRIP))       spin_reg <= 16'(SPIN_CLAMP);
                else if (signed'(r16[15:0]) < -16'(SPIN_TRIP)) spin_reg <= -16'(SPIN_CLAMP);
                else                                           spin_reg <= r16[15:0];
            end
            ST_ROTR: begin
                rot_reg <= r16[15:0];
                wk_reg  <= '0;
            end
            ST_W_V:  v_reg <= r15[15:0] + rot_reg;
            ST_W_OUT: begin
                case (wk_reg)
                    2'd0:    w1_reg <= r16[31:0];
                    2'd1:    w2_reg <= r16[31:0];
                    default: w3_reg <= r16[31:0];
                endcase
                wk_reg <= wk_reg + 1'b1;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.wheel_one_rate   <= w1_reg;
                    m_data_reg.wheel_two_rate   <= w2_reg;
                    m_data_reg.wheel_three_rate <= w3_reg;
                    m_data_reg.speed_over_flag  <= sticky_reg[0];
                    m_data_reg.spin_high_flag   <= sticky_reg[1];
                    m_data_reg.spin_low_flag    <= sticky_reg[2];
                end
            end
            default: ;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_T_RUN || state_reg == ST_A_RUN ||
                      state_reg == ST_V1_RUN || state_reg == ST_V2_RUN ||
                      state_reg == ST_W_RUN))
        else $error("cordic result outside a wait state");
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_speed_reg <= EVT_SAT && cnt_hi_reg <= EVT_SAT && cnt_lo_reg <= EVT_SAT)
        else $error("event counter past saturation");
    a_sticky_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (!sticky_reg[0] || cnt_speed_reg == EVT_SAT) &&
        (!sticky_reg[1] || cnt_hi_reg == EVT_SAT) &&
        (!sticky_reg[2] || cnt_lo_reg == EVT_SAT))
        else $error("sticky flag without saturated counter");
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished result not presented");

endmodule

@@ test/omni_velocity_loop_three_wheel_tb.sv @@
// ----------------------------------------------------------------------------
// omni_velocity_loop_three_wheel_tb
// Self-checking bench: drives polar velocity and heading items through the
// velocity loop, predicts the three wheel rates and sticky clamp flags with a
// bit-exact model of its own, and compares every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omni_velocity_loop_three_wheel_tb;
    import ovl_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 95;

    // ------------------------------------------------------------------------
    class wheel_rate_board;
        bit [12:0] tgt_speed;
        bit [15:0] tgt_dir;
        longint    tgt_spin;
        bit [12:0] spd_limit;
        bit [23:0] scale;
        bit [3:0]  evt_cnt [3];
        bit [2:0]  sticky;
        out_item_t rate_queue [$];
        int        mismatches;
        int        checked;
        longint    atan_q [16] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

        function new();
            tgt_speed = 0; tgt_dir = 0; tgt_spin = 0;
            spd_limit = 2000; scale = 24'd65536;
            evt_cnt = '{0, 0, 0}; sticky = 0;
            mismatches = 0; checked = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [23:0] val);
            case (idx)
                REG_TARGET_SPEED: tgt_speed = val[12:0];
                REG_TARGET_DIR:   tgt_dir = val[15:0];
                REG_TARGET_SPIN:  tgt_spin = longint'($signed(val[10:0]));
                REG_SPEED_LIMIT:  spd_limit = val[12:0];
                REG_PULSE_SCALE:  scale = val;
                default: ;
            endcase
        endfunction

        function longint rnd(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint sat15(longint v);
            return v > 32767 ? 32767 : (v < -32767 ? -32767 : v);
        endfunction

        // cos/sin of a binary angle, Q1.15
        function void sincos(bit [15:0] ang, output longint c, output longint s);
            bit [31:0] z, t;
            bit        flip;
            int        zi;
            longint    x, y, zs, dx, dy;
            z = {ang, 16'h0000};
            t = z + 32'h40000000;
            flip = t[31];
            if (flip) z = z + 32'h80000000;
            zi = z;
            zs = longint'(zi);
            x = 652032875; y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (zs >= 0) begin
                    x -= dx; y += dy; zs -= atan_q[i];
                end else begin
                    x += dx; y -= dy; zs += atan_q[i];
                end
            end
            x = sat15(rnd(x, 15));
            y = sat15(rnd(y, 15));
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint magnitude(longint xi, longint yi, output bit [15:0] ang);
            bit [31:0] z, t;
            longint    x, y, dx, dy;
            x = xi; y = yi; z = 0;
            if (x == 0 && y == 0) begin
                ang = 0;
                return 0;
            end
            if (x < 0) begin
                x = -x; y = -y; z = 32'h80000000;
            end
            x *= 65536; y *= 65536;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z = z + atan_q[i][31:0];
                end else begin
                    x -= dx; y += dy; z = z - atan_q[i][31:0];
                end
            end
            t = z + 32'h8000;
            ang = t[31:16];
            return rnd(x * 652032875, 46);
        endfunction

        function longint axis_limit(longint e);
            longint a;
            a = e < 0 ? -e : e;
            if (a >= 1500) return e < 0 ? -1500 : 1500;
            if (a <= 50) return 0;
            return e;
        endfunction

        function void bump(int k);
            bit [3:0] c;
            c = evt_cnt[k] + 4'd1;
            if (c > EVT_MAX) begin
                c = EVT_SAT;
                sticky[k] = 1'b1;
            end
            evt_cnt[k] = c;
        endfunction

        function void note_input(in_item_t it);
            longint    c, s, tx, ty, ax, ay, ex, ey, m, spd, spin, rot, lim;
            longint    v [3];
            bit [15:0] dir, rel;
            bit [31:0] r;
            out_item_t o;
            lim = longint'(spd_limit);
            sincos(tgt_dir, c, s);
            tx = rnd(longint'(tgt_speed) * c, 15);
            ty = rnd(longint'(tgt_speed) * s, 15);
            sincos(it.actual_direction, c, s);
            ax = rnd(longint'(it.actual_speed) * c, 15);
            ay = rnd(longint'(it.actual_speed) * s, 15);
            ex = rnd(axis_limit(tx - ax) * 22938, 15);
            ey = axis_limit(ty - ay);
            m = magnitude(ex, ey, dir);
            // error vector cap and floor
            if (m >= 250) begin
                ex = ex * 250 / m;
                ey = ey * 250 / m;
            end else if (m < 50) begin
                ex = 0; ey = 0;
            end
            spd = magnitude(ex + tx, ey + ty, dir);
            if (spd >= lim) spd = lim;
            spd = rnd(spd * 76895, 16);
            spin = rnd(tgt_spin * 76895, 16);
            if (spd > lim + 1000) begin
                spd = lim;
                bump(0);
            end
            if (spin > 300) begin
                spin = 200;
                bump(1);
            end else if (spin < -300) begin
                spin = -200;
                bump(2);
            end
            rot = rnd(spin * 333217, 16);
            rel = dir - it.heading;
            sincos(rel, c, s);
            v[0] = rnd(spd * c, 15) + rot;
            sincos(rel + 16'd21845, c, s);
            v[1] = rnd(spd * c, 15) + rot;
            sincos(16'd21845 - rel, c, s);
            v[2] = rnd(spd * c, 15) + rot;
            r = 32'(rnd(v[0] * longint'(scale), 16)); o.wheel_one_rate = r;
            r = 32'(rnd(v[1] * longint'(scale), 16)); o.wheel_two_rate = r;
            r = 32'(rnd(v[2] * longint'(scale), 16)); o.wheel_three_rate = r;
            o.speed_over_flag = sticky[0];
            o.spin_high_flag = sticky[1];
            o.spin_low_flag = sticky[2];
            rate_queue.push_back(o);
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            $display("mismatch at result %0d: %s got %0d want %0d", checked, what, got, want);
        endtask

        task check_result(out_item_t got);
            out_item_t w;
            if (rate_queue.size() == 0) begin
                report("unexpected result, wheel_one_rate", got.wheel_one_rate, 0);
                return;
            end
            w = rate_queue.pop_front();
            if (got.wheel_one_rate !== w.wheel_one_rate)
                report("wheel_one_rate", got.wheel_one_rate, w.wheel_one_rate);
            if (got.wheel_two_rate !== w.wheel_two_rate)
                report("wheel_two_rate", got.wheel_two_rate, w.wheel_two_rate);
            if (got.wheel_three_rate !== w.wheel_three_rate)
                report("wheel_three_rate", got.wheel_three_rate, w.wheel_three_rate);
            if (got.speed_over_flag !== w.speed_over_flag)
                report("speed_over_flag", got.speed_over_flag, w.speed_over_flag);
            if (got.spin_high_flag !== w.spin_high_flag)
                report("spin_high_flag", got.spin_high_flag, w.spin_high_flag);
            if (got.spin_low_flag !== w.spin_low_flag)
                report("spin_low_flag", got.spin_low_flag, w.spin_low_flag);
            checked++;
        endtask
    endclass
    // ------------------------------------------------------------------------

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    wheel_rate_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int sent = 0;

    omni_velocity_loop_three_wheel dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("omni_velocity_loop_three_wheel verification failed");
            $finish;
        end
    end

    task automatic write_reg(bit [2:0] idx, bit [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_input(it);
        sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.rate_queue.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_setting(bit [12:0] spd, bit [15:0] dir, bit [10:0] spin,
                                bit [12:0] lim, bit [23:0] ps);
        write_reg(REG_TARGET_SPEED, 24'(spd));
        write_reg(REG_TARGET_DIR, 24'(dir));
        write_reg(REG_TARGET_SPIN, 24'(spin));
        write_reg(REG_SPEED_LIMIT, 24'(lim));
        write_reg(REG_PULSE_SCALE, ps);
        // unused index, must leave every register alone
        write_reg(3'($urandom_range(7, 5)), 24'($urandom));
    endtask

    function automatic in_item_t make(int spd, int dir, int hdg);
        in_item_t it;
        it.actual_speed = 13'(spd);
        it.actual_direction = 16'(dir);
        it.heading = 16'(hdg);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int sel;
        sel = $urandom_range(99);
        it.heading = 16'($urandom);
        if (sel < 35) begin
            // close to the target vector: deadband and small error region
            it.actual_speed = board.tgt_speed + 13'($urandom_range(300)) - 13'd150;
            it.actual_direction = board.tgt_dir + 16'($urandom_range(600)) - 16'd300;
        end else if (sel < 85) begin
            it.actual_speed = 13'($urandom_range(8000));
            it.actual_direction = 16'($urandom);
        end else begin
            it.actual_speed = 13'($urandom);
            it.actual_direction = 16'($urandom);
        end
        return it;
    endfunction

    initial begin
        int n_spd, n_spin;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: zero command vector
        send_item(make(0, 0, 0));
        send_item(make(8000, 0, 0));
        send_item(make(8191, -32768, 32767));
        send_item(make(8000, 32767, -32768));
        send_item(make(0, 16384, 16384));
        send_item(make(30, -16384, 0));
        drain();

        load_setting(3000, 16384, 0, 8000, 65536);
        send_item(make(3000, 16384, 0));        // no error at all
        send_item(make(3040, 16384, 100));      // inside the axis deadband
        send_item(make(2900, 16400, -100));     // small error, below the cap
        send_item(make(2600, 16384, 0));        // mid error
        send_item(make(0, 0, 0));               // axis clamp and error cap
        send_item(make(8191, -16384, 32767));
        send_item(make(8000, -32768, -32768));
        send_item(make(1, 32767, 21845));
        drain();

        load_setting(8000, -32768, 1023, 8000, 24'hFFFFFF);
        repeat (6) send_item(make(0, 0, $urandom));
        drain();

        load_setting(0, 32767, -1024, 0, 0);
        repeat (5) send_item(make($urandom_range(8191), $urandom, $urandom));
        drain();

        for (int k = 0; k < RAND_PHASES; k++) begin
            if (k < 4) begin
                send_idle_pct = 21; recv_idle_pct = 54;
            end else if (k < 8) begin
                send_idle_pct = 54; recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            n_spd = $urandom_range(8000);
            n_spin = $urandom_range(2047) - 1024;
            if (k % 3 == 0) n_spin = $urandom_range(1023, 260);
            if (k % 3 == 1) n_spin = -$urandom_range(1024, 260);
            if (k == 0)
                load_setting(8000, 0, 1023, 8000, 24'hFFFFFF);
            else if (k == 1)
                load_setting(0, -32768, -1024, 0, 0);
            else if (k == 5)
                load_setting(13'(n_spd), 16'($urandom), 11'(n_spin),
                             13'($urandom_range(8000, 6500)),
                             24'($urandom_range(200000)));
            else
                load_setting(13'(n_spd), 16'($urandom), 11'(n_spin),
                             13'($urandom_range(8000)),
                             24'($urandom_range(24'hFFFFFF)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (k == 9 && i == 10) hold_req++;
                send_item(random_item());
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        $display("%0d items sent, %0d results checked over %0d settings",
                 sent, board.checked, RAND_PHASES + 4);
        $display("spin and speed clamps, deadband, error cap and a long output stall included");
        if (board.mismatches == 0 && board.rate_queue.size() == 0) begin
            $display("omni_velocity_loop_three_wheel verification clean");
        end else begin
            $display("omni_velocity_loop_three_wheel verification failed");
        end
        $finish;
    end

endmodule
